// ===== rtl/tlc_pkg.sv =====
// Shared types, codes and constants of the traffic light controller.
package tlc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int PERIOD_W  = 7;
  localparam int SHOW_W    = 8;
  localparam int LAMP_W    = 6;
  localparam int BTN_N     = 4;
  localparam int TMR_N     = 4;
  localparam int COLOR_N   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd2;

  localparam logic [CFG_W-1:0] TICKS_PER_SECOND_RESET = 16'd100;
  localparam logic [CFG_W-1:0] BLINK_TICKS_RESET      = 16'd25;
  localparam logic [CFG_W-1:0] TIMEOUT_TICKS_RESET    = 16'd1000;

  // Timer slots
  localparam int TMR_A       = 0;
  localparam int TMR_B       = 1;
  localparam int TMR_BLINK   = 2;
  localparam int TMR_TIMEOUT = 3;

  // Button bits
  localparam int BTN_MODE = 0;
  localparam int BTN_UP   = 1;
  localparam int BTN_DOWN = 2;
  localparam int BTN_SAVE = 3;

  typedef logic [PERIOD_W-1:0] period_t;

  localparam period_t INIT_PERIOD [COLOR_N] = '{7'd5, 7'd2, 7'd3};

  typedef enum logic [1:0] {
    MODE_DISPLAY    = 2'd0,
    MODE_EDIT_RED   = 2'd1,
    MODE_EDIT_AMBER = 2'd2,
    MODE_EDIT_GREEN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PHASE_RED   = 2'd0,
    PHASE_AMBER = 2'd1,
    PHASE_GREEN = 2'd2
  } phase_t;

  typedef struct packed {
    logic [TMR_N-1:0]            start;
    logic [TMR_N-1:0][CFG_W-1:0] dur;
  } timer_cmd_t;

  typedef struct packed {
    logic [LAMP_W-1:0]        lamps_on;
    logic signed [SHOW_W-1:0] display_a;
    logic signed [SHOW_W-1:0] display_b;
    mode_t                    current_mode;
    logic                     save_indicator;
  } result_t;

endpackage

// ===== rtl/tlc_in_if.sv =====
// Request channel carrying one tick of button levels.
interface tlc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::BTN_N-1:0]     button_levels;

  modport source (output valid, output button_levels, input ready);
  modport sink   (input valid, input button_levels, output ready);
endinterface

// ===== rtl/tlc_out_if.sv =====
// Result channel carrying lamps, displays, mode and save indicator.
interface tlc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [tlc_pkg::LAMP_W-1:0]            lamps_on;
  logic signed [tlc_pkg::SHOW_W-1:0]     display_a;
  logic signed [tlc_pkg::SHOW_W-1:0]     display_b;
  logic [1:0]                            current_mode;
  logic                                  save_indicator;

  modport source (output valid, output lamps_on, output display_a, output display_b,
                  output current_mode, output save_indicator, input ready);
  modport sink   (input valid, input lamps_on, input display_a, input display_b,
                  input current_mode, input save_indicator, output ready);
endinterface

// ===== rtl/tlc_buttons.sv =====
// Press-then-release event capture for the four buttons.
module tlc_buttons (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [tlc_pkg::BTN_N-1:0] levels,
  input  logic [tlc_pkg::BTN_N-1:0] ev_next,
  output logic [tlc_pkg::BTN_N-1:0] ev_pend
);

  logic [tlc_pkg::BTN_N-1:0] held;
  logic [tlc_pkg::BTN_N-1:0] events;

  // latch an event on release of a held button
  assign ev_pend = events | (held & ~levels);

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= '0;
      events <= '0;
    end else if (step) begin
      held   <= levels;
      events <= ev_next;
    end
  end

endmodule

// ===== rtl/tlc_timers.sv =====
// Four tick-driven down counters: road A, road B, blink and timeout.
module tlc_timers #(
  parameter int TIMER_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  tlc_pkg::timer_cmd_t       cmd,
  output logic [tlc_pkg::TMR_N-1:0] exp_dec
);

  localparam int WW = (TIMER_BITS > tlc_pkg::CFG_W) ? TIMER_BITS : tlc_pkg::CFG_W;
  localparam logic [WW-1:0] MAX_W = WW'((64'd1 << TIMER_BITS) - 64'd1);

  logic [TIMER_BITS-1:0]     cnt [tlc_pkg::TMR_N];
  logic [TIMER_BITS-1:0]     cnt_next [tlc_pkg::TMR_N];
  logic [tlc_pkg::TMR_N-1:0] expired;
  logic [tlc_pkg::TMR_N-1:0] expired_next;

  always_comb begin
    logic [WW-1:0]         dur_w;
    logic [WW-1:0]         sat;
    logic [TIMER_BITS-1:0] dec;
    for (int k = 0; k < tlc_pkg::TMR_N; k++) begin
      // advance a running counter, flag expiry when it hits zero
      dec        = (cnt[k] != '0) ? cnt[k] - TIMER_BITS'(1) : cnt[k];
      exp_dec[k] = expired[k] | (cnt[k] == TIMER_BITS'(1));
      // reload with the duration clamped to the counter range
      dur_w = WW'(cmd.dur[k]);
      sat   = (dur_w > MAX_W) ? MAX_W : dur_w;
      cnt_next[k]     = cmd.start[k] ? sat[TIMER_BITS-1:0] : dec;
      expired_next[k] = cmd.start[k] ? (cmd.dur[k] == '0) : exp_dec[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < tlc_pkg::TMR_N; k++) begin
        cnt[k] <= '0;
      end
      expired <= '1;
    end else if (step) begin
      cnt     <= cnt_next;
      expired <= expired_next;
    end
  end

endmodule

// ===== rtl/tlc_core.sv =====
// Mode state machine, road phase sequencing and period editing.
module tlc_core #(
  parameter int MAX_PERIOD = 99
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  logic [tlc_pkg::CFG_W-1:0] ticks_per_second,
  input  logic [tlc_pkg::CFG_W-1:0] blink_ticks,
  input  logic [tlc_pkg::CFG_W-1:0] timeout_ticks,
  input  logic [tlc_pkg::BTN_N-1:0] ev_pend,
  input  logic [tlc_pkg::TMR_N-1:0] exp_dec,
  output logic [tlc_pkg::BTN_N-1:0] ev_next,
  output tlc_pkg::timer_cmd_t       cmd,
  output tlc_pkg::result_t          res
);

  localparam tlc_pkg::period_t MAX_P = tlc_pkg::PERIOD_W'(MAX_PERIOD);

  tlc_pkg::mode_t   mode, mode_next;
  tlc_pkg::phase_t  phase_a, phase_a_next;
  tlc_pkg::phase_t  phase_b, phase_b_next;
  tlc_pkg::period_t saved [tlc_pkg::COLOR_N];
  tlc_pkg::period_t saved_next [tlc_pkg::COLOR_N];
  tlc_pkg::period_t edit [tlc_pkg::COLOR_N];
  tlc_pkg::period_t edit_next [tlc_pkg::COLOR_N];
  tlc_pkg::period_t count_a [tlc_pkg::COLOR_N];
  tlc_pkg::period_t count_a_next [tlc_pkg::COLOR_N];
  tlc_pkg::period_t count_b [tlc_pkg::COLOR_N];
  tlc_pkg::period_t count_b_next [tlc_pkg::COLOR_N];
  logic [tlc_pkg::LAMP_W-1:0] lamp, lamp_next;
  logic [tlc_pkg::SHOW_W-1:0] shown_a, shown_a_next;
  logic [tlc_pkg::SHOW_W-1:0] shown_b, shown_b_next;
  logic                       toggle, toggle_next;

  function automatic tlc_pkg::phase_t next_phase(tlc_pkg::phase_t p);
    tlc_pkg::phase_t n;
    unique case (p)
      tlc_pkg::PHASE_RED:   n = tlc_pkg::PHASE_GREEN;
      tlc_pkg::PHASE_AMBER: n = tlc_pkg::PHASE_RED;
      tlc_pkg::PHASE_GREEN: n = tlc_pkg::PHASE_AMBER;
      default:              n = tlc_pkg::PHASE_RED;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] lamp3(logic [1:0] idx);
    return 3'(3'b001 << idx);
  endfunction

  always_comb begin
    logic [1:0]       col;
    logic [1:0]       col1;
    tlc_pkg::period_t v;
    logic             to_exp;
    logic             go_display;

    mode_next    = mode;
    phase_a_next = phase_a;
    phase_b_next = phase_b;
    saved_next   = saved;
    edit_next    = edit;
    count_a_next = count_a;
    count_b_next = count_b;
    lamp_next    = lamp;
    shown_a_next = shown_a;
    shown_b_next = shown_b;
    toggle_next  = toggle;
    ev_next      = ev_pend;
    go_display   = 1'b0;
    to_exp       = 1'b0;
    v            = '0;

    cmd.start                        = '0;
    cmd.dur[tlc_pkg::TMR_A]          = ticks_per_second;
    cmd.dur[tlc_pkg::TMR_B]          = ticks_per_second;
    cmd.dur[tlc_pkg::TMR_BLINK]      = blink_ticks;
    cmd.dur[tlc_pkg::TMR_TIMEOUT]    = timeout_ticks;

    col  = 2'(mode) - 2'd1;
    col1 = col + 2'd1;

    if (mode == tlc_pkg::MODE_DISPLAY) begin
      if (ev_pend[tlc_pkg::BTN_MODE]) begin
        // enter red edit
        mode_next    = tlc_pkg::MODE_EDIT_RED;
        lamp_next    = '0;
        ev_next      = '0;
        edit_next[0] = saved[0];
        shown_b_next = tlc_pkg::SHOW_W'(2);
        shown_a_next = {1'b0, saved[0]};
        cmd.start[tlc_pkg::TMR_TIMEOUT] = 1'b1;
      end else begin
        if (exp_dec[tlc_pkg::TMR_A]) begin
          lamp_next[2:0] = lamp3(phase_a);
          shown_a_next   = {1'b0, count_a[phase_a]};
          if (count_a[phase_a] == '0) begin
            phase_a_next           = next_phase(phase_a);
            count_a_next[phase_a]  = saved[phase_a];
          end else begin
            count_a_next[phase_a]  = count_a[phase_a] - tlc_pkg::PERIOD_W'(1);
            cmd.start[tlc_pkg::TMR_A] = 1'b1;
          end
        end
        if (exp_dec[tlc_pkg::TMR_B]) begin
          lamp_next[5:3] = lamp3(phase_b);
          shown_b_next   = {1'b0, count_b[phase_b]};
          if (count_b[phase_b] == '0) begin
            phase_b_next           = next_phase(phase_b);
            count_b_next[phase_b]  = saved[phase_b];
          end else begin
            count_b_next[phase_b]  = count_b[phase_b] - tlc_pkg::PERIOD_W'(1);
            cmd.start[tlc_pkg::TMR_B] = 1'b1;
          end
        end
      end
    end else begin
      if (ev_pend[tlc_pkg::BTN_MODE]) begin
        ev_next[tlc_pkg::BTN_MODE] = 1'b0;
        if (mode == tlc_pkg::MODE_EDIT_GREEN) begin
          mode_next  = tlc_pkg::MODE_DISPLAY;
          go_display = 1'b1;
        end else begin
          mode_next       = tlc_pkg::mode_t'(2'(mode) + 2'd1);
          lamp_next       = '0;
          ev_next         = '0;
          edit_next[col1] = saved[col1];
          shown_b_next    = tlc_pkg::SHOW_W'(col1) + tlc_pkg::SHOW_W'(2);
          shown_a_next    = {1'b0, saved[col1]};
        end
        cmd.start[tlc_pkg::TMR_TIMEOUT] = 1'b1;
      end else begin
        if (exp_dec[tlc_pkg::TMR_BLINK]) begin
          lamp_next = lamp ^ {lamp3(col), lamp3(col)};
          cmd.start[tlc_pkg::TMR_BLINK] = 1'b1;
        end
        v = edit[col];
        if (ev_pend[tlc_pkg::BTN_UP]) begin
          ev_next[tlc_pkg::BTN_UP] = 1'b0;
          cmd.start[tlc_pkg::TMR_TIMEOUT] = 1'b1;
          v = (v >= MAX_P) ? tlc_pkg::PERIOD_W'(1) : v + tlc_pkg::PERIOD_W'(1);
          shown_a_next = {1'b0, v};
        end
        if (ev_pend[tlc_pkg::BTN_DOWN]) begin
          ev_next[tlc_pkg::BTN_DOWN] = 1'b0;
          cmd.start[tlc_pkg::TMR_TIMEOUT] = 1'b1;
          v = (v <= tlc_pkg::PERIOD_W'(1)) ? MAX_P : v - tlc_pkg::PERIOD_W'(1);
          shown_a_next = {1'b0, v};
        end
        if (ev_pend[tlc_pkg::BTN_SAVE]) begin
          ev_next[tlc_pkg::BTN_SAVE] = 1'b0;
          cmd.start[tlc_pkg::TMR_TIMEOUT] = 1'b1;
          saved_next[col] = v;
          toggle_next     = ~toggle;
        end
        edit_next[col] = v;
      end
      // a fresh timeout start with zero duration expires at once
      to_exp = cmd.start[tlc_pkg::TMR_TIMEOUT] ? (timeout_ticks == '0)
                                               : exp_dec[tlc_pkg::TMR_TIMEOUT];
      if (to_exp) begin
        mode_next  = tlc_pkg::MODE_DISPLAY;
        go_display = 1'b1;
      end
    end

    if (go_display) begin
      phase_a_next = tlc_pkg::PHASE_RED;
      phase_b_next = tlc_pkg::PHASE_GREEN;
      count_a_next = saved_next;
      count_b_next = saved_next;
      lamp_next    = '0;
      cmd.start[tlc_pkg::TMR_A] = 1'b1;
      cmd.start[tlc_pkg::TMR_B] = 1'b1;
      cmd.dur[tlc_pkg::TMR_A]   = '0;
      cmd.dur[tlc_pkg::TMR_B]   = '0;
    end

    res.lamps_on       = lamp_next;
    res.display_a      = $signed(shown_a_next);
    res.display_b      = $signed(shown_b_next);
    res.current_mode   = mode_next;
    res.save_indicator = toggle_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= tlc_pkg::MODE_DISPLAY;
      phase_a <= tlc_pkg::PHASE_RED;
      phase_b <= tlc_pkg::PHASE_GREEN;
      saved   <= tlc_pkg::INIT_PERIOD;
      edit    <= tlc_pkg::INIT_PERIOD;
      count_a <= tlc_pkg::INIT_PERIOD;
      count_b <= tlc_pkg::INIT_PERIOD;
      lamp    <= '0;
      shown_a <= '0;
      shown_b <= '0;
      toggle  <= 1'b0;
    end else if (step) begin
      mode    <= mode_next;
      phase_a <= phase_a_next;
      phase_b <= phase_b_next;
      saved   <= saved_next;
      edit    <= edit_next;
      count_a <= count_a_next;
      count_b <= count_b_next;
      lamp    <= lamp_next;
      shown_a <= shown_a_next;
      shown_b <= shown_b_next;
      toggle  <= toggle_next;
    end
  end

endmodule

// ===== rtl/traffic_light_controller_with_setup.sv =====
// Top level of the two-road traffic light controller with period setup.
//
// Usage: every request on the buttons channel is one tick carrying the four
// debounced button levels (mode, up, down, save). For each request the block
// returns exactly one result on the lights channel: six lamp bits, the two
// display values, the current mode and the save indicator.
// The three timing registers (ticks per countdown step, blink interval,
// edit timeout) are written through cfg_write/cfg_index/cfg_data while no
// request is in flight; an index beyond the list is dropped.
// Each request passes through the input register, then the tick update into the
// result register. Throughput: one request per cycle while the receiver
// keeps ready high, set by the single tick update between those two registers.
// Reset (rst, synchronous) brings display mode, road A red, road B green,
// periods 5/2/3, all timers expired and lamps off; registers return to
// 100/25/1000. When the receiver holds ready low, the result register and
// the input register fill and then buttons.ready drops until a result is
// taken; nothing is lost or repeated.
module traffic_light_controller_with_setup #(
  parameter int MAX_PERIOD = 99,
  parameter int TIMER_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tlc_pkg::CFG_W-1:0]     cfg_data,
  tlc_in_if.sink                        buttons,
  tlc_out_if.source                     lights
);

  logic [tlc_pkg::CFG_W-1:0] ticks_per_second;
  logic [tlc_pkg::CFG_W-1:0] blink_ticks;
  logic [tlc_pkg::CFG_W-1:0] timeout_ticks;

  logic                      s1_valid;
  logic [tlc_pkg::BTN_N-1:0] s1_levels;
  logic                      out_valid;
  tlc_pkg::result_t          out_res;

  logic                      advance;
  logic                      in_fire;
  logic [tlc_pkg::BTN_N-1:0] ev_pend;
  logic [tlc_pkg::BTN_N-1:0] ev_next;
  logic [tlc_pkg::TMR_N-1:0] exp_dec;
  tlc_pkg::timer_cmd_t       cmd;
  tlc_pkg::result_t          res;

  // Configuration registers: write only, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= tlc_pkg::TICKS_PER_SECOND_RESET;
      blink_ticks      <= tlc_pkg::BLINK_TICKS_RESET;
      timeout_ticks    <= tlc_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tlc_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        tlc_pkg::REG_BLINK_TICKS:      blink_ticks      <= cfg_data;
        tlc_pkg::REG_TIMEOUT_TICKS:    timeout_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the held tick when the result register is free or being drained
  assign advance       = s1_valid && (!out_valid || lights.ready);
  assign buttons.ready = !s1_valid || advance;
  assign in_fire       = buttons.valid && buttons.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_fire || (s1_valid && !advance);
      out_valid <= advance || (out_valid && !lights.ready);
    end
  end

  // Payload registers: hold until the next load
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_levels <= buttons.button_levels;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  tlc_buttons u_buttons (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .levels  (s1_levels),
    .ev_next (ev_next),
    .ev_pend (ev_pend)
  );

  tlc_timers #(
    .TIMER_BITS (TIMER_BITS)
  ) u_timers (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .cmd     (cmd),
    .exp_dec (exp_dec)
  );

  tlc_core #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .ticks_per_second (ticks_per_second),
    .blink_ticks      (blink_ticks),
    .timeout_ticks    (timeout_ticks),
    .ev_pend          (ev_pend),
    .exp_dec          (exp_dec),
    .ev_next          (ev_next),
    .cmd              (cmd),
    .res              (res)
  );

  assign lights.valid          = out_valid;
  assign lights.lamps_on       = out_res.lamps_on;
  assign lights.display_a      = out_res.display_a;
  assign lights.display_b      = out_res.display_b;
  assign lights.current_mode   = out_res.current_mode;
  assign lights.save_indicator = out_res.save_indicator;

endmodule

// ===== rtl/tlc_checker.sv =====
// Port-level checks of the traffic light controller, bound to the top level.
module tlc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [tlc_pkg::LAMP_W-1:0]         lamps_on,
  input logic signed [tlc_pkg::SHOW_W-1:0]  display_a,
  input logic signed [tlc_pkg::SHOW_W-1:0]  display_b,
  input logic [1:0]                         current_mode,
  input logic                               save_indicator
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lamps_on) && $stable(display_a)
      && $stable(display_b) && $stable(current_mode) && $stable(save_indicator))
    else $error("stalled result changed");

  // edit modes show the mode number plus one on road B
  a_edit_number: assert property (@(posedge clk) disable iff (rst)
    out_valid && current_mode != 2'd0 |->
      $unsigned(display_b) == ({6'd0, current_mode} + 8'd1))
    else $error("edit mode number wrong on display B");

  // edit blinking lights the same lamp on both roads
  a_edit_blink: assert property (@(posedge clk) disable iff (rst)
    out_valid && current_mode != 2'd0 |-> lamps_on[2:0] == lamps_on[5:3])
    else $error("roads blink differently in edit mode");

  // each road lights at most one lamp
  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(lamps_on[2:0]) && $onehot0(lamps_on[5:3]))
    else $error("more than one lamp lit on a road");

endmodule

bind traffic_light_controller_with_setup tlc_checker u_tlc_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (lights.valid),
  .out_ready      (lights.ready),
  .lamps_on       (lights.lamps_on),
  .display_a      (lights.display_a),
  .display_b      (lights.display_b),
  .current_mode   (lights.current_mode),
  .save_indicator (lights.save_indicator)
);
